[rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tuvd_pkg.sv]
package tuvd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int DIM_W  = 11;
	localparam int TILE_W = 4;
	localparam int IDX_W  = 16;
	localparam int ADDR_W = 20;
	localparam int CNT_W  = 32;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [BYTE_W-1:0] SKIP_CONT = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_TILE_WIDTH   = 3'd2,
		REG_TILE_HEIGHT  = 3'd3,
		REG_TILES_ACROSS = 3'd4,
		REG_TILES_DOWN   = 3'd5,
		REG_TOTAL_FRAMES = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_FLAGS    = 3'd0,
		PH_COUNT_LO = 3'd1,
		PH_COUNT_HI = 3'd2,
		PH_SKIP     = 3'd3,
		PH_PIXEL    = 3'd4
	} parse_phase_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_STEP,
		CS_DIV,
		CS_MUL1,
		CS_MUL2,
		CS_TILE,
		CS_WAIT
	} ctrl_state_t;

	typedef struct packed {
		logic [DIM_W-1:0]  frame_width;
		logic [DIM_W-1:0]  frame_height;
		logic [TILE_W-1:0] tile_width;
		logic [TILE_W-1:0] tile_height;
		logic [DIM_W-1:0]  tiles_across;
		logic [DIM_W-1:0]  tiles_down;
		logic [CNT_W-1:0]  total_frames;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic div_start;
		logic mul1;
		logic mul2;
		logic tile;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_tile;
		logic div_done;
	} dp_status_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] val;
		logic              done;
		logic [CNT_W-1:0]  fnum;
		logic              oor;
		logic              fin;
	} res_t;

	function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
		logic [TILE_W-1:0] r;
		r = v;
		if (v == '0)
			r = TILE_W'(1);
		else if (v > TILE_W'(8))
			r = TILE_W'(8);
		return r;
	endfunction

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (int'(v) > maxv)
			r = DIM_W'(maxv);
		return r;
	endfunction

endpackage

[rtl/tuvd_regs.sv]
module tuvd_regs import tuvd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= DIM_W'(320);
			cfg_q.frame_height <= DIM_W'(240);
			cfg_q.tile_width   <= TILE_W'(8);
			cfg_q.tile_height  <= TILE_W'(8);
			cfg_q.tiles_across <= DIM_W'(40);
			cfg_q.tiles_down   <= DIM_W'(30);
			cfg_q.total_frames <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[DIM_W-1:0];
				REG_TILE_WIDTH:   cfg_q.tile_width   <= cfg_data[TILE_W-1:0];
				REG_TILE_HEIGHT:  cfg_q.tile_height  <= cfg_data[TILE_W-1:0];
				REG_TILES_ACROSS: cfg_q.tiles_across <= cfg_data[DIM_W-1:0];
				REG_TILES_DOWN:   cfg_q.tiles_down   <= cfg_data[DIM_W-1:0];
				REG_TOTAL_FRAMES: cfg_q.total_frames <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/tuvd_div.sv]
module tuvd_div import tuvd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IDX_W-1:0]  dividend,
	input  logic [DIM_W-1:0]  divisor,
	output logic [IDX_W-1:0]  quotient,
	output logic [DIM_W-1:0]  remainder,
	output logic              done
);

	localparam int STEP_W = $clog2(IDX_W + 1);

	logic [IDX_W-1:0]  quo_q;
	logic [DIM_W-1:0]  rem_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DIM_W:0]    trial;
	logic              ge;
	logic [DIM_W-1:0]  rem_nxt;

	// One quotient bit per cycle, restoring form.
	always_comb begin
		trial   = {rem_q, quo_q[IDX_W-1]};
		ge      = (trial >= {1'b0, divisor});
		rem_nxt = ge ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= STEP_W'(IDX_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - STEP_W'(1);
			done_q <= (cnt_q == STEP_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[IDX_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

[rtl/tuvd_dp.sv]
module tuvd_dp import tuvd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  ctrl_cmd_t          cmd,
	output dp_status_t         sts,
	input  logic [BYTE_W-1:0]  stream_byte,
	output logic               write_enable,
	output logic [ADDR_W-1:0]  pixel_address,
	output logic [BYTE_W-1:0]  pixel_value,
	output logic               frame_done,
	output logic [CNT_W-1:0]   frame_number,
	output logic               out_of_range,
	output logic               stream_finished
);

	logic [BYTE_W-1:0] byte_q;
	parse_phase_t      phase_q, phase_d;
	logic [IDX_W-1:0]  updates_left_q, ul_d;
	logic [IDX_W-1:0]  tile_index_q, idx_d;
	logic [ADDR_W-1:0] tile_base_q;
	logic [2:0]        tile_row_q, row_d;
	logic [2:0]        tile_col_q, col_d;
	logic              tile_outside_q;
	logic [CNT_W-1:0]  frame_count_q, fc_d;
	res_t              res_d, res_q, out_q;

	logic [TILE_W-1:0] tw, th;
	logic [DIM_W-1:0]  fw, fh, ta;
	logic [IDX_W-1:0]  skip_sum;
	logic [13:0]       row_off;

	logic [IDX_W-1:0]  quo;
	logic [DIM_W-1:0]  rem;
	logic              div_done;

	logic [14:0]       px_s1, px_s2;
	logic [ADDR_W-1:0] py_s1;
	logic              ty_out_s1;
	logic [30:0]       prod_s2;
	logic              outside_s2;

	always_comb begin
		tw       = clamp_tile(cfg.tile_width);
		th       = clamp_tile(cfg.tile_height);
		fw       = clamp_dim(cfg.frame_width, MAX_WIDTH);
		fh       = clamp_dim(cfg.frame_height, MAX_HEIGHT);
		ta       = (cfg.tiles_across == '0) ? DIM_W'(1) : cfg.tiles_across;
		skip_sum = tile_index_q + IDX_W'(byte_q);
		row_off  = 14'(tile_row_q) * 14'(fw);
	end

	// Per-byte parse step.
	always_comb begin
		res_d   = '0;
		phase_d = phase_q;
		ul_d    = updates_left_q;
		idx_d   = tile_index_q;
		row_d   = tile_row_q;
		col_d   = tile_col_q;
		fc_d    = frame_count_q;
		unique case (phase_q)
			PH_FLAGS: begin
				if (frame_count_q >= cfg.total_frames) begin
					res_d.fin = 1'b1;
				end else begin
					idx_d   = '0;
					phase_d = PH_COUNT_LO;
				end
			end
			PH_COUNT_LO: begin
				ul_d    = IDX_W'(byte_q);
				phase_d = PH_COUNT_HI;
			end
			PH_COUNT_HI: begin
				ul_d = {byte_q, updates_left_q[7:0]};
				if (ul_d == '0) begin
					fc_d       = frame_count_q + CNT_W'(1);
					phase_d    = PH_FLAGS;
					res_d.done = 1'b1;
				end else begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				idx_d = skip_sum;
				if (byte_q != SKIP_CONT)
					phase_d = PH_PIXEL;
			end
			PH_PIXEL: begin
				if (tile_outside_q) begin
					res_d.oor = 1'b1;
				end else begin
					res_d.we   = 1'b1;
					res_d.addr = ADDR_W'(tile_base_q + ADDR_W'(row_off) + ADDR_W'(tile_col_q));
					res_d.val  = byte_q;
				end
				if ({1'b0, tile_col_q} + TILE_W'(1) >= tw) begin
					col_d = '0;
					if ({1'b0, tile_row_q} + TILE_W'(1) >= th) begin
						row_d = '0;
						idx_d = tile_index_q + IDX_W'(1);
						ul_d  = updates_left_q - IDX_W'(1);
						if (ul_d == '0) begin
							fc_d       = frame_count_q + CNT_W'(1);
							phase_d    = PH_FLAGS;
							res_d.done = 1'b1;
						end else begin
							phase_d = PH_SKIP;
						end
					end else begin
						row_d = tile_row_q + 3'd1;
					end
				end else begin
					col_d = tile_col_q + 3'd1;
				end
			end
			default: phase_d = PH_FLAGS;
		endcase
		res_d.fnum = fc_d;
	end

	tuvd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (skip_sum),
		.divisor   (ta),
		.quotient  (quo),
		.remainder (rem),
		.done      (div_done)
	);

	assign sts.need_tile = (phase_q == PH_SKIP) && (byte_q != SKIP_CONT);
	assign sts.div_done  = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FLAGS;
			updates_left_q <= '0;
			tile_index_q   <= '0;
			tile_base_q    <= '0;
			tile_row_q     <= '0;
			tile_col_q     <= '0;
			tile_outside_q <= 1'b0;
			frame_count_q  <= '0;
		end else if (cmd.step) begin
			phase_q        <= phase_d;
			updates_left_q <= ul_d;
			tile_index_q   <= idx_d;
			tile_row_q     <= row_d;
			tile_col_q     <= col_d;
			frame_count_q  <= fc_d;
		end else if (cmd.tile) begin
			tile_outside_q <= outside_s2;
			tile_base_q    <= outside_s2 ? '0 : ADDR_W'(prod_s2 + 31'(px_s2));
			tile_row_q     <= '0;
			tile_col_q     <= '0;
		end
	end

	// Tile placement: column and row products, then the row-pitch product.
	always_ff @(posedge clk) begin
		if (cmd.load)
			byte_q <= stream_byte;
		if (cmd.step)
			res_q <= res_d;
		if (cmd.mul1) begin
			px_s1     <= 15'(rem) * 15'(tw);
			py_s1     <= ADDR_W'(quo) * ADDR_W'(th);
			ty_out_s1 <= (quo >= IDX_W'(cfg.tiles_down));
		end
		if (cmd.mul2) begin
			prod_s2    <= 31'(py_s1) * 31'(fw);
			px_s2      <= px_s1;
			outside_s2 <= ty_out_s1
				|| (16'(px_s1) + 16'(tw) > 16'(fw))
				|| (21'(py_s1) + 21'(th) > 21'(fh));
		end
		if (cmd.emit)
			out_q <= cmd.step ? res_d : res_q;
	end

	assign write_enable    = out_q.we;
	assign pixel_address   = out_q.addr;
	assign pixel_value     = out_q.val;
	assign frame_done      = out_q.done;
	assign frame_number    = out_q.fnum;
	assign out_of_range    = out_q.oor;
	assign stream_finished = out_q.fin;

endmodule

[rtl/tuvd_ctrl.sv]
module tuvd_ctrl import tuvd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = CS_STEP;
				end
			end
			CS_STEP: begin
				cmd.step = 1'b1;
				if (sts.need_tile) begin
					cmd.div_start = 1'b1;
					state_d       = CS_DIV;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = CS_IDLE;
				end else begin
					state_d = CS_WAIT;
				end
			end
			CS_DIV: begin
				if (sts.div_done)
					state_d = CS_MUL1;
			end
			CS_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = CS_MUL2;
			end
			CS_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = CS_TILE;
			end
			CS_TILE: begin
				cmd.tile = 1'b1;
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = CS_IDLE;
				end else begin
					state_d = CS_WAIT;
				end
			end
			CS_WAIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/tile_update_video_decoder_unit.sv]
// Tile-update video decoder: one stream byte in, one result word out.
// Flags, count and pixel bytes are parsed in the step state; the result word is registered when emitted.
// A skip byte that starts a tile first runs a bit-serial divide of the tile index
// by tiles_across, then two multiply stages for the address.
// One byte is in work at a time; a new byte is taken while a result word waits.
// Asynchronous reset restores register defaults and expects a flags byte.
`include "assert_macros.svh"

module tile_update_video_decoder_unit import tuvd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     stream_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  write_enable,
	output logic [ADDR_W-1:0]     pixel_address,
	output logic [BYTE_W-1:0]     pixel_value,
	output logic                  frame_done,
	output logic [CNT_W-1:0]      frame_number,
	output logic                  out_of_range,
	output logic                  stream_finished
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	tuvd_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tuvd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tuvd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.stream_byte     (stream_byte),
		.write_enable    (write_enable),
		.pixel_address   (pixel_address),
		.pixel_value     (pixel_value),
		.frame_done      (frame_done),
		.frame_number    (frame_number),
		.out_of_range    (out_of_range),
		.stream_finished (stream_finished)
	);

	`AST_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a byte while busy")
	`AST_NEXT(a_emit_sets_valid, cmd.emit, out_valid, "emitted word not presented")
	`AST_IMPL(a_oor_no_write, out_valid, !(write_enable && out_of_range), "write on outside tile")
	`AST_IMPL(a_finished_idle, out_valid && stream_finished, !write_enable && !frame_done, "ignored byte has effects")

endmodule
